@@ hdl/owbm_pkg.sv @@
package owbm_pkg;

   // Raw command codes on the request channel.
   localparam logic [2:0] CMD_TICK     = 3'd0;
   localparam logic [2:0] CMD_BUS_RST  = 3'd1;
   localparam logic [2:0] CMD_PUSH     = 3'd2;
   localparam logic [2:0] CMD_START_TX = 3'd3;
   localparam logic [2:0] CMD_START_RX = 3'd4;

   // Transmit queue geometry.
   localparam int TX_DEPTH = 16;
   localparam int TX_IDX_W = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
   localparam int TX_LVL_W = $clog2(TX_DEPTH + 1);

   // Classified operation handed from the front end to the slot engine.
   typedef enum logic [2:0] {
      OP_TICK     = 3'd0,
      OP_BUS_RST  = 3'd1,
      OP_PUSH     = 3'd2,
      OP_START_TX = 3'd3,
      OP_START_RX = 3'd4,
      OP_NOP      = 3'd5
   } op_type;

   // Kind of the slot that is in progress.
   typedef enum logic [4:0] {
      SLOT_NONE  = 5'b00001,
      SLOT_W1    = 5'b00010,
      SLOT_W0    = 5'b00100,
      SLOT_READ  = 5'b01000,
      SLOT_RESET = 5'b10000
   } slot_kind_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] tx_data;
      logic [7:0] rx_count;
      logic       line_level;
   } item_type;

   typedef struct packed {
      logic       drive_valid;
      logic       drive_level;
      logic [8:0] wait_us;
      logic       busy_res;
      logic       rx_valid;
      logic [7:0] rx_data;
      logic       no_device;
      logic       refused;
   } rsp_type;

   // Wait in microseconds after entering a stage of a slot.
   function automatic logic [8:0] wait_for(slot_kind_type k, logic [2:0] s);
      logic [8:0] w;
      w = 9'd0;
      unique case (k)
         SLOT_W1: begin
            case (s)
               3'd1:    w = 9'd6;
               3'd2:    w = 9'd64;
               default: w = 9'd0;
            endcase
         end
         SLOT_W0: begin
            case (s)
               3'd1:    w = 9'd60;
               3'd2:    w = 9'd10;
               default: w = 9'd0;
            endcase
         end
         SLOT_READ: begin
            case (s)
               3'd1:    w = 9'd6;
               3'd2:    w = 9'd9;
               3'd3:    w = 9'd55;
               default: w = 9'd0;
            endcase
         end
         SLOT_RESET: begin
            case (s)
               3'd1:    w = 9'd3;
               3'd2:    w = 9'd480;
               3'd3:    w = 9'd70;
               3'd4:    w = 9'd410;
               default: w = 9'd0;
            endcase
         end
         default: w = 9'd0;
      endcase
      return w;
   endfunction

   // Line level driven at a stage of a slot.
   function automatic logic level_for(slot_kind_type k, logic [2:0] s);
      logic l;
      l = 1'b0;
      unique case (k)
         SLOT_W1, SLOT_W0: l = (s == 3'd1) || (s == 3'd2);
         SLOT_READ:        l = (s >= 3'd1) && (s <= 3'd3);
         SLOT_RESET:       l = (s == 3'd0) || ((s >= 3'd2) && (s <= 3'd4));
         default:          l = 1'b0;
      endcase
      return l;
   endfunction

   // Final stage index of each slot kind.
   function automatic logic [2:0] last_stage(slot_kind_type k);
      logic [2:0] ls;
      ls = 3'd0;
      unique case (k)
         SLOT_W1, SLOT_W0: ls = 3'd2;
         SLOT_READ:        ls = 3'd3;
         SLOT_RESET:       ls = 3'd4;
         default:          ls = 3'd0;
      endcase
      return ls;
   endfunction

   // Write slot kind that sends the given bit of a byte.
   function automatic slot_kind_type kind_for_bit(logic [7:0] b, logic [2:0] pos);
      return b[pos] ? SLOT_W1 : SLOT_W0;
   endfunction

endpackage

@@ hdl/owbm_front.sv @@
module owbm_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [2:0]        req_cmd,
   input  logic [7:0]        req_tx_data,
   input  logic [7:0]        req_rx_count,
   input  logic              req_line_level,
   output logic              item_valid,
   output owbm_pkg::item_type item,
   input  logic              item_pop
);

   owbm_pkg::item_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   owbm_pkg::item_type decoded;
   logic       push;

   // Classify the raw command into an operation.
   always_comb begin
      decoded.tx_data    = req_tx_data;
      decoded.rx_count   = req_rx_count;
      decoded.line_level = req_line_level;
      unique case (req_cmd)
         owbm_pkg::CMD_TICK:     decoded.op = owbm_pkg::OP_TICK;
         owbm_pkg::CMD_BUS_RST:  decoded.op = owbm_pkg::OP_BUS_RST;
         owbm_pkg::CMD_PUSH:     decoded.op = owbm_pkg::OP_PUSH;
         owbm_pkg::CMD_START_TX: decoded.op = owbm_pkg::OP_START_TX;
         owbm_pkg::CMD_START_RX: decoded.op = owbm_pkg::OP_START_RX;
         default:                decoded.op = owbm_pkg::OP_NOP;
      endcase
   end

   // Two-entry queue toward the slot engine.
   assign req_ready  = (count_ff != 2'd2);
   assign push       = req_valid && req_ready;
   assign item_valid = (count_ff != 2'd0);
   assign item       = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = item_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !item_pop) begin
         count_in = count_ff + 2'd1;
      end else if (!push && item_pop) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage carries no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= decoded;
      end
   end

endmodule

@@ hdl/owbm_engine.sv @@
module owbm_engine (
   input  logic              clock,
   input  logic              reset,
   input  logic              item_valid,
   input  owbm_pkg::item_type item,
   output logic              item_pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output owbm_pkg::rsp_type rsp
);

   localparam int IW = owbm_pkg::TX_IDX_W;
   localparam int LW = owbm_pkg::TX_LVL_W;

   owbm_pkg::slot_kind_type kind_ff, kind_in;
   logic [2:0]    stage_ff, stage_in;
   logic [3:0]    bitpos_ff, bitpos_in;
   logic [7:0]    shift_ff, shift_in;
   logic [7:0]    left_ff, left_in;
   logic          presence_ff, presence_in;
   logic [IW-1:0] head_ff, head_in;
   logic [IW-1:0] tail_ff, tail_in;
   logic [LW-1:0] level_ff, level_in;
   logic [7:0]    tx_mem [owbm_pkg::TX_DEPTH];
   logic [7:0]    head_data_ff;
   logic          rsp_valid_ff;
   owbm_pkg::rsp_type rsp_ff, rsp_in;
   logic          step;
   logic          busy;
   logic          push_ok;

   // An item is executed when the result register is free or being drained.
   assign step     = item_valid && (!rsp_valid_ff || rsp_ready);
   assign item_pop = step;
   assign busy     = (kind_ff != owbm_pkg::SLOT_NONE);

   // Slot sequencing and queue bookkeeping for one item.
   always_comb begin
      kind_in     = kind_ff;
      stage_in    = stage_ff;
      bitpos_in   = bitpos_ff;
      shift_in    = shift_ff;
      left_in     = left_ff;
      presence_in = presence_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      level_in    = level_ff;
      push_ok     = 1'b0;
      rsp_in      = '0;

      case (item.op)
         owbm_pkg::OP_TICK: begin
            if (busy) begin
               if (kind_ff == owbm_pkg::SLOT_READ && stage_ff == 3'd2 && item.line_level) begin
                  shift_in[bitpos_ff[2:0]] = 1'b1;
               end
               if (kind_ff == owbm_pkg::SLOT_RESET && stage_ff == 3'd3) begin
                  presence_in = item.line_level;
               end
               rsp_in.drive_valid = 1'b1;
               rsp_in.drive_level = owbm_pkg::level_for(kind_ff, stage_ff);
               if (stage_ff >= owbm_pkg::last_stage(kind_ff)) begin
                  stage_in = 3'd0;
                  if (kind_ff == owbm_pkg::SLOT_W1 || kind_ff == owbm_pkg::SLOT_W0) begin
                     bitpos_in = 4'(bitpos_ff + 4'd1);
                     if (bitpos_in >= 4'd8) begin
                        // Byte sent: fetch the next queued byte, if any.
                        if (level_ff == '0) begin
                           kind_in = owbm_pkg::SLOT_NONE;
                        end else begin
                           shift_in  = head_data_ff;
                           head_in   = (head_ff == IW'(owbm_pkg::TX_DEPTH - 1)) ?
                                       '0 : IW'(head_ff + 1'b1);
                           level_in  = LW'(level_ff - 1'b1);
                           bitpos_in = 4'd0;
                           kind_in   = owbm_pkg::kind_for_bit(shift_in, 3'd0);
                        end
                     end else begin
                        kind_in = owbm_pkg::kind_for_bit(shift_ff, bitpos_in[2:0]);
                     end
                  end else if (kind_ff == owbm_pkg::SLOT_READ) begin
                     bitpos_in = 4'(bitpos_ff + 4'd1);
                     if (bitpos_in >= 4'd8) begin
                        // Byte received: hand it out and start the next one.
                        rsp_in.rx_valid = 1'b1;
                        rsp_in.rx_data  = shift_in;
                        if (left_ff == 8'd0) begin
                           kind_in = owbm_pkg::SLOT_NONE;
                        end else begin
                           shift_in  = 8'd0;
                           bitpos_in = 4'd0;
                           kind_in   = owbm_pkg::SLOT_READ;
                           left_in   = 8'(left_ff - 8'd1);
                        end
                     end
                  end else begin
                     kind_in = owbm_pkg::SLOT_NONE;
                  end
               end else begin
                  stage_in = 3'(stage_ff + 3'd1);
               end
            end
         end
         owbm_pkg::OP_PUSH: begin
            if (level_ff >= LW'(owbm_pkg::TX_DEPTH)) begin
               rsp_in.refused = 1'b1;
            end else begin
               push_ok  = 1'b1;
               tail_in  = (tail_ff == IW'(owbm_pkg::TX_DEPTH - 1)) ?
                          '0 : IW'(tail_ff + 1'b1);
               level_in = LW'(level_ff + 1'b1);
            end
         end
         owbm_pkg::OP_BUS_RST, owbm_pkg::OP_START_TX, owbm_pkg::OP_START_RX: begin
            if (busy) begin
               rsp_in.refused = 1'b1;
            end else begin
               stage_in = 3'd0;
               if (item.op == owbm_pkg::OP_BUS_RST) begin
                  kind_in = owbm_pkg::SLOT_RESET;
               end else if (item.op == owbm_pkg::OP_START_TX) begin
                  if (level_ff != '0) begin
                     shift_in  = head_data_ff;
                     head_in   = (head_ff == IW'(owbm_pkg::TX_DEPTH - 1)) ?
                                 '0 : IW'(head_ff + 1'b1);
                     level_in  = LW'(level_ff - 1'b1);
                     bitpos_in = 4'd0;
                     kind_in   = owbm_pkg::kind_for_bit(shift_in, 3'd0);
                  end
               end else begin
                  if (item.rx_count != 8'd0) begin
                     shift_in  = 8'd0;
                     bitpos_in = 4'd0;
                     kind_in   = owbm_pkg::SLOT_READ;
                     left_in   = 8'(item.rx_count - 8'd1);
                  end else begin
                     left_in   = 8'd0;
                  end
               end
            end
         end
         default: begin
         end
      endcase

      // Status reported after this item's update.
      rsp_in.wait_us   = owbm_pkg::wait_for(kind_in, stage_in);
      rsp_in.busy_res  = (kind_in != owbm_pkg::SLOT_NONE);
      rsp_in.no_device = presence_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff      <= owbm_pkg::SLOT_NONE;
         stage_ff     <= 3'd0;
         bitpos_ff    <= 4'd0;
         shift_ff     <= 8'd0;
         left_ff      <= 8'd0;
         presence_ff  <= 1'b0;
         head_ff      <= '0;
         tail_ff      <= '0;
         level_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (step) begin
            kind_ff     <= kind_in;
            stage_ff    <= stage_in;
            bitpos_ff   <= bitpos_in;
            shift_ff    <= shift_in;
            left_ff     <= left_in;
            presence_ff <= presence_in;
            head_ff     <= head_in;
            tail_ff     <= tail_in;
            level_ff    <= level_in;
         end
         if (step) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Transmit byte storage and the result register carry no reset.
   always_ff @(posedge clock) begin
      if (step && push_ok) begin
         tx_mem[tail_ff] <= item.tx_data;
      end
      if (step) begin
         rsp_ff <= rsp_in;
      end
   end

   // The byte at the queue head is kept registered for the next load. A push
   // into an empty queue lands at the head and is taken directly.
   always_ff @(posedge clock) begin
      if (step) begin
         if (push_ok && (tail_ff == head_in)) begin
            head_data_ff <= item.tx_data;
         end else begin
            head_data_ff <= tx_mem[head_in];
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

@@ hdl/one_wire_bus_master.sv @@
// One-wire bus master, sequenced one bit slot at a time.
// Request channel (req_*): a command with its operands and the sampled line
// level. A tick advances the current slot by one stage; other commands start
// a bus reset, queue a transmit byte, start transmitting the queued bytes or
// start receiving a number of bytes. Every request yields exactly one
// response on the rsp_* channel: the line drive for this tick, the wait in
// microseconds until the next tick, busy, a completed received byte, the
// presence result of the last bus reset and a refusal flag.
// A front end decodes requests into a two-entry queue; the slot engine takes
// one entry per cycle into its response register while that register is free
// or being drained. After a request transfer, the request is held in a queue
// entry and then its response in the response register; throughput is one
// request per cycle when the receiver does not stall.
// When the receiver stalls, the response register holds, the queue fills and
// req_ready drops after at most two more requests. Reset (synchronous, active
// high) empties the queue, clears the slot state, the presence flag and the
// transmit queue pointers; queued transmit bytes are lost.
module one_wire_bus_master (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [2:0] req_cmd,
   input  logic [7:0] req_tx_data,
   input  logic [7:0] req_rx_count,
   input  logic       req_line_level,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_drive_valid,
   output logic       rsp_drive_level,
   output logic [8:0] rsp_wait_us,
   output logic       rsp_busy_res,
   output logic       rsp_rx_valid,
   output logic [7:0] rsp_rx_data,
   output logic       rsp_no_device,
   output logic       rsp_refused
);

   owbm_pkg::item_type item;
   owbm_pkg::rsp_type  rsp;
   logic item_valid;
   logic item_pop;

   // Request decode and queue.
   owbm_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_cmd        (req_cmd),
      .req_tx_data    (req_tx_data),
      .req_rx_count   (req_rx_count),
      .req_line_level (req_line_level),
      .item_valid     (item_valid),
      .item           (item),
      .item_pop       (item_pop)
   );

   // Slot sequencing and response register.
   owbm_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp        (rsp)
   );

   assign rsp_drive_valid = rsp.drive_valid;
   assign rsp_drive_level = rsp.drive_level;
   assign rsp_wait_us     = rsp.wait_us;
   assign rsp_busy_res    = rsp.busy_res;
   assign rsp_rx_valid    = rsp.rx_valid;
   assign rsp_rx_data     = rsp.rx_data;
   assign rsp_no_device   = rsp.no_device;
   assign rsp_refused     = rsp.refused;

endmodule

@@ tb/owbm_checker.sv @@
`timescale 1ns / 1ps

module owbm_checker
   import owbm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [2:0]  req_cmd,
   input  logic [7:0]  req_tx_data,
   input  logic [7:0]  req_rx_count,
   input  logic        req_line_level,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic        rsp_drive_valid,
   input  logic        rsp_drive_level,
   input  logic [8:0]  rsp_wait_us,
   input  logic        rsp_busy_res,
   input  logic        rsp_rx_valid,
   input  logic [7:0]  rsp_rx_data,
   input  logic        rsp_no_device,
   input  logic        rsp_refused,
   output int unsigned fault_count,
   output int unsigned outstanding,
   output int unsigned responses_seen,
   output int unsigned rx_bytes_seen,
   output int unsigned refusals_seen
);

   // What one stage of a slot does: the level it drives, the wait after
   // entering it, and whether it closes the slot.
   typedef struct packed {
      logic       drive;
      logic [8:0] wait_us;
      logic       last;
   } stage_spec_type;

   localparam int N_FIELDS = 8;

   string field_name [N_FIELDS] = '{"drive_valid", "drive_level", "wait_us", "busy_res",
                                    "rx_valid", "rx_data", "no_device", "refused"};

   // Mirror of the slot engine state.
   slot_kind_type slot_now      = SLOT_NONE;
   logic [2:0]    stage_now     = 3'd0;
   logic [3:0]    bit_now       = 4'd0;
   logic [7:0]    shift_now     = 8'd0;
   logic [7:0]    rx_bytes_left = 8'd0;
   logic          presence_fail = 1'b0;
   logic [7:0]    tx_backlog [$];

   // Responses predicted but not yet delivered, oldest first.
   rsp_type slot_results_due [$];

   function automatic stage_spec_type stage_of(slot_kind_type k, logic [2:0] s);
      stage_spec_type sp;
      sp = '0;
      case (k)
         SLOT_W1, SLOT_W0: begin
            sp.drive = (s != 3'd0);
            sp.last  = (s >= 3'd2);
            if (s == 3'd1) sp.wait_us = (k == SLOT_W1) ? 9'd6 : 9'd60;
            if (s == 3'd2) sp.wait_us = (k == SLOT_W1) ? 9'd64 : 9'd10;
         end
         SLOT_READ: begin
            sp.drive = (s != 3'd0);
            sp.last  = (s >= 3'd3);
            case (s)
               3'd1:    sp.wait_us = 9'd6;
               3'd2:    sp.wait_us = 9'd9;
               3'd3:    sp.wait_us = 9'd55;
               default: sp.wait_us = 9'd0;
            endcase
         end
         SLOT_RESET: begin
            // The reset slot opens released, then holds the line low.
            sp.drive = (s != 3'd1);
            sp.last  = (s >= 3'd4);
            case (s)
               3'd1:    sp.wait_us = 9'd3;
               3'd2:    sp.wait_us = 9'd480;
               3'd3:    sp.wait_us = 9'd70;
               3'd4:    sp.wait_us = 9'd410;
               default: sp.wait_us = 9'd0;
            endcase
         end
         default: sp.last = 1'b1;
      endcase
      return sp;
   endfunction

   function automatic slot_kind_type bit_slot(logic [7:0] b, logic [3:0] pos);
      return b[pos[2:0]] ? SLOT_W1 : SLOT_W0;
   endfunction

   // Take the next byte off the transmit backlog, or go idle when it is empty.
   task automatic load_tx_byte();
      if (tx_backlog.size() == 0) begin
         slot_now = SLOT_NONE;
      end else begin
         shift_now = tx_backlog.pop_front();
         bit_now   = 4'd0;
         slot_now  = bit_slot(shift_now, bit_now);
      end
   endtask

   // Open the next byte of a receive run, or go idle when none is left.
   task automatic load_rx_byte();
      if (rx_bytes_left == 8'd0) begin
         slot_now = SLOT_NONE;
      end else begin
         shift_now     = 8'd0;
         bit_now       = 4'd0;
         slot_now      = SLOT_READ;
         rx_bytes_left = rx_bytes_left - 8'd1;
      end
   endtask

   // Apply one request to the mirrored state and queue the response it yields.
   task automatic advance_slot_model(input logic [2:0] cmd, input logic [7:0] txd,
                                     input logic [7:0] cnt, input logic line);
      rsp_type        due;
      stage_spec_type sp;
      logic           busy;
      due  = '0;
      busy = (slot_now != SLOT_NONE);
      case (cmd)
         CMD_TICK: begin
            if (busy) begin
               sp = stage_of(slot_now, stage_now);
               // Read slots sample the line at stage 2, reset slots the
               // presence pulse at stage 3.
               if (slot_now == SLOT_READ && stage_now == 3'd2 && line)
                  shift_now[bit_now[2:0]] = 1'b1;
               if (slot_now == SLOT_RESET && stage_now == 3'd3)
                  presence_fail = line;
               due.drive_valid = 1'b1;
               due.drive_level = sp.drive;
               if (sp.last) begin
                  stage_now = 3'd0;
                  if (slot_now == SLOT_W1 || slot_now == SLOT_W0) begin
                     bit_now = bit_now + 4'd1;
                     if (bit_now >= 4'd8) load_tx_byte();
                     else slot_now = bit_slot(shift_now, bit_now);
                  end else if (slot_now == SLOT_READ) begin
                     bit_now = bit_now + 4'd1;
                     if (bit_now >= 4'd8) begin
                        due.rx_valid = 1'b1;
                        due.rx_data  = shift_now;
                        load_rx_byte();
                     end
                  end else begin
                     slot_now = SLOT_NONE;
                  end
               end else begin
                  stage_now = stage_now + 3'd1;
               end
            end
         end
         CMD_PUSH: begin
            // Pushes are taken even while busy, but not into a full backlog.
            if (tx_backlog.size() >= TX_DEPTH) due.refused = 1'b1;
            else tx_backlog.push_back(txd);
         end
         CMD_BUS_RST, CMD_START_TX, CMD_START_RX: begin
            if (busy) begin
               due.refused = 1'b1;
            end else begin
               stage_now = 3'd0;
               if (cmd == CMD_BUS_RST) begin
                  slot_now = SLOT_RESET;
               end else if (cmd == CMD_START_TX) begin
                  load_tx_byte();
               end else begin
                  rx_bytes_left = cnt;
                  load_rx_byte();
               end
            end
         end
         default: ;
      endcase
      sp = stage_of(slot_now, stage_now);
      due.wait_us   = sp.wait_us;
      due.busy_res  = (slot_now != SLOT_NONE);
      due.no_device = presence_fail;
      slot_results_due.push_back(due);
   endtask

   task automatic report_fault(input string msg);
      if (fault_count < 30)
         $display("[%0t] response %0d: %s", $realtime, responses_seen, msg);
      fault_count++;
   endtask

   // Score response transfers against the oldest prediction, then predict
   // from the request transfer of the same edge.
   always @(posedge clock) begin
      rsp_type    due;
      logic [8:0] want [N_FIELDS];
      logic [8:0] got  [N_FIELDS];
      if (reset) begin
         slot_now      = SLOT_NONE;
         stage_now     = 3'd0;
         bit_now       = 4'd0;
         shift_now     = 8'd0;
         rx_bytes_left = 8'd0;
         presence_fail = 1'b0;
         tx_backlog.delete();
         slot_results_due.delete();
         fault_count    = 0;
         responses_seen = 0;
         rx_bytes_seen  = 0;
         refusals_seen  = 0;
         outstanding   <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = '{9'(rsp_drive_valid), 9'(rsp_drive_level), rsp_wait_us,
                    9'(rsp_busy_res), 9'(rsp_rx_valid), 9'(rsp_rx_data),
                    9'(rsp_no_device), 9'(rsp_refused)};
            if (slot_results_due.size() == 0) begin
               report_fault("response transfer with nothing predicted");
            end else begin
               due  = slot_results_due.pop_front();
               want = '{9'(due.drive_valid), 9'(due.drive_level), due.wait_us,
                        9'(due.busy_res), 9'(due.rx_valid), 9'(due.rx_data),
                        9'(due.no_device), 9'(due.refused)};
               for (int i = 0; i < N_FIELDS; i++) begin
                  if (got[i] !== want[i])
                     report_fault($sformatf("%s expected %0d, got %0d",
                                            field_name[i], want[i], got[i]));
               end
            end
            responses_seen++;
            if (rsp_rx_valid === 1'b1) rx_bytes_seen++;
            if (rsp_refused === 1'b1) refusals_seen++;
         end
         if (req_valid && req_ready)
            advance_slot_model(req_cmd, req_tx_data, req_rx_count, req_line_level);
         outstanding <= slot_results_due.size();
      end
   end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
   import owbm_pkg::*;

   // Command codes that the block must ignore.
   localparam logic [2:0] CMD_RSVD_5 = 3'd5;
   localparam logic [2:0] CMD_RSVD_6 = 3'd6;
   localparam logic [2:0] CMD_RSVD_7 = 3'd7;

   // Ticks that one full operation takes.
   localparam int TICKS_PER_BUS_RST = 5;
   localparam int TICKS_PER_TX_BYTE = 24;
   localparam int TICKS_PER_RX_BYTE = 32;

   localparam int RANDOM_ITEMS = 1050;

   logic       clock;
   logic       reset          = 1'b1;
   logic       req_valid      = 1'b0;
   logic       req_ready;
   logic [2:0] req_cmd        = CMD_TICK;
   logic [7:0] req_tx_data    = 8'd0;
   logic [7:0] req_rx_count   = 8'd0;
   logic       req_line_level = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready      = 1'b0;
   logic       rsp_drive_valid;
   logic       rsp_drive_level;
   logic [8:0] rsp_wait_us;
   logic       rsp_busy_res;
   logic       rsp_rx_valid;
   logic [7:0] rsp_rx_data;
   logic       rsp_no_device;
   logic       rsp_refused;

   int unsigned fault_count;
   int unsigned outstanding;
   int unsigned responses_seen;
   int unsigned rx_bytes_seen;
   int unsigned refusals_seen;

   // Stimulus bookkeeping: bytes waiting in the block's transmit queue.
   int qcount    = 0;
   int n_items   = 0;
   int n_resets  = 0;
   int n_tx_runs = 0;
   int n_rx_runs = 0;
   int send_calm = 0;
   int rsp_calm  = 0;
   int rsp_stall = 0;

   one_wire_bus_master u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_cmd         (req_cmd),
      .req_tx_data     (req_tx_data),
      .req_rx_count    (req_rx_count),
      .req_line_level  (req_line_level),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_drive_valid (rsp_drive_valid),
      .rsp_drive_level (rsp_drive_level),
      .rsp_wait_us     (rsp_wait_us),
      .rsp_busy_res    (rsp_busy_res),
      .rsp_rx_valid    (rsp_rx_valid),
      .rsp_rx_data     (rsp_rx_data),
      .rsp_no_device   (rsp_no_device),
      .rsp_refused     (rsp_refused)
   );

   owbm_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_cmd         (req_cmd),
      .req_tx_data     (req_tx_data),
      .req_rx_count    (req_rx_count),
      .req_line_level  (req_line_level),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_drive_valid (rsp_drive_valid),
      .rsp_drive_level (rsp_drive_level),
      .rsp_wait_us     (rsp_wait_us),
      .rsp_busy_res    (rsp_busy_res),
      .rsp_rx_valid    (rsp_rx_valid),
      .rsp_rx_data     (rsp_rx_data),
      .rsp_no_device   (rsp_no_device),
      .rsp_refused     (rsp_refused),
      .fault_count     (fault_count),
      .outstanding     (outstanding),
      .responses_seen  (responses_seen),
      .rx_bytes_seen   (rx_bytes_seen),
      .refusals_seen   (refusals_seen)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Hard stop in case the block hangs.
   initial begin
      #1_500_000;
      $display("TB_ERROR");
      $finish;
   end

   // Response side: random stalls, mostly short, with calm stretches.
   always @(posedge clock) begin
      int r;
      r = $urandom_range(0, 99);
      if (rsp_calm > 0) begin
         rsp_calm--;
         rsp_ready <= 1'b1;
      end else if (rsp_stall > 0) begin
         rsp_stall--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         if (r < 2) rsp_calm = $urandom_range(40, 200);
         else if (r < 18) rsp_stall = $urandom_range(1, 3);
         else if (r < 21) rsp_stall = $urandom_range(8, 40);
      end
   end

   // One request transfer, preceded by a random gap. Returns at the edge
   // of the transfer.
   task automatic send_req(input logic [2:0] cmd, input logic [7:0] txd,
                           input logic [7:0] cnt, input logic line,
                           input bit ignored = 1'b0);
      int gap;
      int r;
      gap = 0;
      r   = $urandom_range(0, 99);
      if (send_calm > 0) send_calm--;
      else if (r < 2) send_calm = $urandom_range(40, 200);
      else if (r < 20) gap = $urandom_range(1, 3);
      else if (r < 23) gap = $urandom_range(8, 30);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_cmd        <= cmd;
      req_tx_data    <= txd;
      req_rx_count   <= cnt;
      req_line_level <= line;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (!ignored) n_items++;
   endtask

   task automatic push_byte(input logic [7:0] data);
      send_req(CMD_PUSH, data, 8'($urandom), 1'($urandom));
      if (qcount < TX_DEPTH) qcount++;
   endtask

   // Hold off the sender until every response has come back.
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   // Ticks with a random line level. Now and then a command is slipped in
   // while the slot runs; pushes only when no transmission is in flight.
   task automatic run_ticks(input int n, input bit allow_push);
      int pick;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 99) < 8) begin
            pick = $urandom_range(0, allow_push ? 6 : 5);
            case (pick)
               0: send_req(CMD_BUS_RST, 8'($urandom), 8'($urandom), 1'($urandom));
               1: send_req(CMD_START_TX, 8'($urandom), 8'($urandom), 1'($urandom));
               2: send_req(CMD_START_RX, 8'($urandom), 8'($urandom), 1'($urandom));
               3: send_req(CMD_RSVD_5, 8'($urandom), 8'($urandom), 1'($urandom), 1'b1);
               4: send_req(CMD_RSVD_6, 8'($urandom), 8'($urandom), 1'($urandom), 1'b1);
               5: send_req(CMD_RSVD_7, 8'($urandom), 8'($urandom), 1'($urandom), 1'b1);
               default: push_byte(8'($urandom));
            endcase
         end
         send_req(CMD_TICK, 8'($urandom), 8'($urandom), 1'($urandom));
      end
   endtask

   task automatic run_bus_reset();
      send_req(CMD_BUS_RST, 8'($urandom), 8'($urandom), 1'($urandom));
      run_ticks(TICKS_PER_BUS_RST, 1'b1);
      n_resets++;
   endtask

   // Queue some bytes, start the transfer and tick until the queue is drained.
   task automatic run_transmit(input int n_push);
      int         r;
      int         ticks;
      logic [7:0] data;
      repeat (n_push) begin
         r    = $urandom_range(0, 9);
         data = (r == 0) ? 8'h00 : (r == 1) ? 8'hFF : 8'($urandom);
         push_byte(data);
      end
      send_req(CMD_START_TX, 8'($urandom), 8'($urandom), 1'($urandom));
      ticks  = qcount * TICKS_PER_TX_BYTE;
      qcount = 0;
      run_ticks(ticks, 1'b0);
      n_tx_runs++;
   endtask

   task automatic run_receive(input int n_bytes);
      send_req(CMD_START_RX, 8'($urandom), 8'(n_bytes), 1'($urandom));
      run_ticks(n_bytes * TICKS_PER_RX_BYTE, 1'b1);
      n_rx_runs++;
   endtask

   // Requests that leave an idle block idle.
   task automatic run_idle_noise();
      repeat ($urandom_range(1, 3)) begin
         case ($urandom_range(0, 3))
            0: send_req(CMD_TICK, 8'($urandom), 8'($urandom), 1'($urandom), 1'b1);
            1: send_req(CMD_RSVD_6, 8'($urandom), 8'($urandom), 1'($urandom), 1'b1);
            2: send_req(CMD_START_RX, 8'($urandom), 8'h00, 1'($urandom), 1'b1);
            default: begin
               if (qcount == 0)
                  send_req(CMD_START_TX, 8'($urandom), 8'($urandom), 1'($urandom), 1'b1);
               else
                  send_req(CMD_RSVD_7, 8'($urandom), 8'($urandom), 1'($urandom), 1'b1);
            end
         endcase
      end
   endtask

   initial begin
      int r;
      int scenario;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Idle block: plain tick and unused codes with extreme operands.
      send_req(CMD_TICK, 8'h00, 8'h00, 1'b0, 1'b1);
      send_req(CMD_RSVD_5, 8'hFF, 8'hFF, 1'b1, 1'b1);
      send_req(CMD_RSVD_6, 8'h00, 8'h00, 1'b0, 1'b1);
      send_req(CMD_RSVD_7, 8'hFF, 8'h00, 1'b1, 1'b1);
      // Start transmit with an empty queue and receive of zero bytes stay idle.
      send_req(CMD_START_TX, 8'h00, 8'h00, 1'b0);
      send_req(CMD_START_RX, 8'hFF, 8'h00, 1'b0);
      // Bus reset with no device answering; starts while busy are refused,
      // a push while busy is taken.
      send_req(CMD_BUS_RST, 8'h00, 8'h00, 1'b0);
      send_req(CMD_BUS_RST, 8'hFF, 8'hFF, 1'b1);
      send_req(CMD_START_TX, 8'h00, 8'h00, 1'b0);
      send_req(CMD_START_RX, 8'h00, 8'hFF, 1'b1);
      push_byte(8'h5A);
      repeat (TICKS_PER_BUS_RST) send_req(CMD_TICK, 8'h00, 8'h00, 1'b1);
      // Second bus reset with a device pulling the line low.
      send_req(CMD_BUS_RST, 8'h00, 8'h00, 1'b0);
      repeat (TICKS_PER_BUS_RST) send_req(CMD_TICK, 8'hFF, 8'hFF, 1'b0);
      // Send the byte queued above: a mix of write-1 and write-0 slots.
      send_req(CMD_START_TX, 8'h00, 8'h00, 1'b0);
      qcount = 0;
      run_ticks(TICKS_PER_TX_BYTE, 1'b0);
      n_resets  += 2;
      n_tx_runs += 1;
      wait_for_drain();

      // Random operations with random content; the third one overfills the
      // transmit queue.
      n_items  = 0;
      scenario = 0;
      while (n_items < RANDOM_ITEMS) begin
         r = $urandom_range(0, 99);
         if (scenario == 2 || r < 2) begin
            run_transmit(TX_DEPTH - qcount + $urandom_range(1, 2));
         end else if (r < 16) begin
            run_bus_reset();
         end else if (r < 50) begin
            run_transmit($urandom_range(1, 2));
         end else if (r < 90) begin
            run_receive(($urandom_range(0, 9) == 0) ? $urandom_range(3, 4)
                                                    : $urandom_range(1, 2));
         end else begin
            run_idle_noise();
         end
         if ($urandom_range(0, 99) < 4) wait_for_drain();
         scenario++;
      end

      wait_for_drain();
      repeat (6) @(posedge clock);
      $display("Sent %0d counted requests over %0d bus resets, %0d transmit runs, %0d receive runs.",
               n_items, n_resets, n_tx_runs, n_rx_runs);
      $display("Checked %0d responses, %0d with a received byte, %0d refused commands.",
               responses_seen, rx_bytes_seen, refusals_seen);
      if (fault_count == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

endmodule

@@ files.f @@
hdl/owbm_pkg.sv
hdl/owbm_front.sv
hdl/owbm_engine.sv
hdl/one_wire_bus_master.sv
tb/owbm_checker.sv
tb/testbench.sv
